>>> design/cck_pkg.sv
// Shared types, constants and helpers for the ChaCha keystream block.
// Used by the quarter-round step unit and the top level; depends on nothing.
package cck_pkg;

  localparam int WORD_W  = 32;
  localparam int NWORDS  = 16;
  localparam int CFG_W   = 64;
  localparam int CFG_IW  = 3;
  localparam int BEAT_W  = 3;
  localparam int RND_W   = 5;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t             state_t [NWORDS];

  // The four ChaCha constant words ("expand 32-byte k").
  localparam word_t SIGMA0 = 32'h61707865;
  localparam word_t SIGMA1 = 32'h3320646e;
  localparam word_t SIGMA2 = 32'h79622d32;
  localparam word_t SIGMA3 = 32'h6b206574;

  // Round counts selected by round_select; code 3 saturates to 20.
  localparam logic [RND_W-1:0] ROUNDS_8  = 5'd8;
  localparam logic [RND_W-1:0] ROUNDS_12 = 5'd12;
  localparam logic [RND_W-1:0] ROUNDS_20 = 5'd20;

  typedef enum logic [CFG_IW-1:0] {
    CFG_KEY_W0     = 3'd0,
    CFG_KEY_W1     = 3'd1,
    CFG_KEY_W2     = 3'd2,
    CFG_KEY_W3     = 3'd3,
    CFG_NONCE_LOW  = 3'd4,
    CFG_NONCE_HIGH = 3'd5,
    CFG_ROUND_SEL  = 3'd6,
    CFG_SUBKEY     = 3'd7
  } cfg_idx_t;

  // Control of the quarter-round step unit.
  typedef struct packed {
    logic       diag;   // 0 column round, 1 diagonal round
    logic [1:0] step;   // which add/xor/rotate of the quarter round
  } qr_ctl_t;

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    rotl = (x << n) | (x >> (6'd32 - {1'b0, n}));
  endfunction

endpackage

>>> design/chacha_keystream_block.sv
// Top level of the ChaCha / HChaCha20 keystream block.
// Depends on cck_pkg and cck_qr_step.
//
//   Channel  Dir  Signals                          Contents
//   in       in   in_tvalid/in_tready/in_tdata     block_counter [31:0]
//   out      out  out_tvalid/out_tready/out_tdata  out_data [63:0]
//                 out_tuser, out_tlast             beat_index [2:0], last_beat
//   cfg      in   cfg_we/cfg_index/cfg_wdata       register writes, no read-back
//
// After a counter is accepted the sequencer runs R rounds (R = 8, 12 or 20;
// 20 in subkey mode) of quarter-round steps, then the feed-forward state, then
// loads the output register. Then one beat per cycle follows while the
// receiver takes them: 8 beats, or 4 in subkey mode. A new counter is taken only
// once the last beat has been loaded. The quarter-round step unit does one
// add/xor/rotate of four quarter rounds per cycle, so a round is four such steps.
// in_tready is high only while the sequencer is idle.
// A stalled output beat holds in the output register; the sequencer waits.
// rst_n is synchronous and active low; it resets control and config registers.
module chacha_keystream_block import cck_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,    // [31:0] block_counter
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,   // [63:0] out_data
  output logic [BEAT_W-1:0] out_tuser,   // [2:0] beat_index
  output logic              out_tlast,   // last_beat
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ROUND = 4'b0010,
    S_FEED  = 4'b0100,
    S_OUT   = 4'b1000
  } fsm_t;

  fsm_t               fsm_r, fsm_nxt;
  logic [CFG_W-1:0]   key_r [4];
  logic [CFG_W-1:0]   nonce_lo_r, nonce_hi_r;
  logic [1:0]         round_sel_r;
  logic               subkey_r;
  word_t              ctr_r;
  state_t             st_r, st_nxt, st_step, init_w;
  logic [1:0]         step_r, step_nxt;
  logic [RND_W-1:0]   rnd_r, rnd_nxt, rnd_last_r, rnd_last_nxt;
  logic [BEAT_W-1:0]  beat_r, beat_nxt, beat_last;
  logic               out_valid_r, out_valid_nxt;
  logic [63:0]        out_data_r, out_data_nxt;
  logic [BEAT_W-1:0]  out_beat_r, out_beat_nxt;
  logic               out_last_r, out_last_nxt;
  qr_ctl_t            qr_ctl;
  word_t              ctr_src;
  logic               in_acc, load_beat, rounds_done;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      nonce_lo_r  <= '0;
      nonce_hi_r  <= '0;
      round_sel_r <= 2'd2;
      subkey_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_W0:     key_r[0]    <= cfg_wdata;
        CFG_KEY_W1:     key_r[1]    <= cfg_wdata;
        CFG_KEY_W2:     key_r[2]    <= cfg_wdata;
        CFG_KEY_W3:     key_r[3]    <= cfg_wdata;
        CFG_NONCE_LOW:  nonce_lo_r  <= cfg_wdata;
        CFG_NONCE_HIGH: nonce_hi_r  <= cfg_wdata;
        CFG_ROUND_SEL:  round_sel_r <= cfg_wdata[1:0];
        CFG_SUBKEY:     subkey_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_tready = (fsm_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign ctr_src   = (fsm_r == S_IDLE) ? in_tdata : ctr_r;

  // Initial state words; also the feed-forward operand in block mode.
  always_comb begin
    init_w[0] = SIGMA0;
    init_w[1] = SIGMA1;
    init_w[2] = SIGMA2;
    init_w[3] = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init_w[4 + 2*i] = key_r[i][31:0];
      init_w[5 + 2*i] = key_r[i][63:32];
    end
    if (subkey_r) begin
      init_w[12] = nonce_lo_r[31:0];
      init_w[13] = nonce_lo_r[63:32];
      init_w[14] = nonce_hi_r[31:0];
      init_w[15] = nonce_hi_r[63:32];
    end else begin
      init_w[12] = ctr_src;
      init_w[13] = nonce_lo_r[31:0];
      init_w[14] = nonce_lo_r[63:32];
      init_w[15] = nonce_hi_r[31:0];
    end
  end

  // Shared quarter-round step unit.
  assign qr_ctl.diag = rnd_r[0];
  assign qr_ctl.step = step_r;

  cck_qr_step u_step (
    .st_i  (st_r),
    .ctl_i (qr_ctl),
    .st_o  (st_step)
  );

  assign rounds_done = (step_r == 2'd3) && (rnd_r == rnd_last_r);
  assign beat_last   = subkey_r ? 3'd3 : 3'd7;
  assign load_beat   = (fsm_r == S_OUT) && (!out_valid_r || out_tready);

  // Last round index for the selected round count.
  always_comb begin
    if (subkey_r) begin
      rnd_last_nxt = ROUNDS_20 - 5'd1;
    end else begin
      case (round_sel_r)
        2'd0:    rnd_last_nxt = ROUNDS_8 - 5'd1;
        2'd1:    rnd_last_nxt = ROUNDS_12 - 5'd1;
        default: rnd_last_nxt = ROUNDS_20 - 5'd1;
      endcase
    end
  end

  // Sequencer: load, rounds, feed-forward, then beats out of words 0 and 1.
  always_comb begin
    fsm_nxt       = fsm_r;
    st_nxt        = st_r;
    step_nxt      = step_r;
    rnd_nxt       = rnd_r;
    beat_nxt      = beat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_beat_nxt  = out_beat_r;
    out_last_nxt  = out_last_r;
    case (fsm_r)
      S_IDLE: begin
        if (in_acc) begin
          st_nxt   = init_w;
          step_nxt = 2'd0;
          rnd_nxt  = '0;
          fsm_nxt  = S_ROUND;
        end
      end
      S_ROUND: begin
        st_nxt   = st_step;
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) rnd_nxt = rnd_r + 5'd1;
        if (rounds_done) fsm_nxt = S_FEED;
      end
      S_FEED: begin
        // Block mode adds the input back; subkey mode moves words 12..15 to 4..7.
        if (subkey_r) begin
          for (int i = 0; i < 4; i++) st_nxt[4 + i] = st_r[12 + i];
        end else begin
          for (int i = 0; i < NWORDS; i++) st_nxt[i] = st_r[i] + init_w[i];
        end
        beat_nxt = '0;
        fsm_nxt  = S_OUT;
      end
      S_OUT: begin
        if (load_beat) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {st_r[1], st_r[0]};
          out_beat_nxt  = beat_r;
          out_last_nxt  = (beat_r == beat_last);
          for (int i = 0; i < NWORDS - 2; i++) st_nxt[i] = st_r[i + 2];
          beat_nxt = beat_r + 3'd1;
          if (beat_r == beat_last) fsm_nxt = S_IDLE;
        end
      end
      default: fsm_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      rnd_r       <= '0;
      beat_r      <= '0;
    end else begin
      fsm_r       <= fsm_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      rnd_r       <= rnd_nxt;
      beat_r      <= beat_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    st_r       <= st_nxt;
    out_data_r <= out_data_nxt;
    out_beat_r <= out_beat_nxt;
    out_last_r <= out_last_nxt;
    if (in_acc) begin
      ctr_r      <= in_tdata;
      rnd_last_r <= rnd_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_beat_r;
  assign out_tlast  = out_last_r;

endmodule

>>> design/cck_qr_step.sv
// One add/xor/rotate step of four ChaCha quarter rounds in parallel.
// Depends on cck_pkg; used by chacha_keystream_block once per cycle.
module cck_qr_step import cck_pkg::*; (
  input  state_t  st_i,
  input  qr_ctl_t ctl_i,
  output state_t  st_o
);

  // Each lane works on one quarter round; the four lanes touch disjoint words.
  always_comb begin
    logic [1:0] jb, jc, jd;
    logic [3:0] ia, ib, ic, id, ix, iy, iz;
    logic [4:0] r;
    word_t      sum;
    st_o = st_i;
    case (ctl_i.step)
      2'd0:    r = 5'd16;
      2'd1:    r = 5'd12;
      2'd2:    r = 5'd8;
      default: r = 5'd7;
    endcase
    for (int j = 0; j < 4; j++) begin
      jb = ctl_i.diag ? 2'(j + 1) : 2'(j);
      jc = ctl_i.diag ? 2'(j + 2) : 2'(j);
      jd = ctl_i.diag ? 2'(j + 3) : 2'(j);
      ia = {2'b00, 2'(j)};
      ib = {2'b01, jb};
      ic = {2'b10, jc};
      id = {2'b11, jd};
      // Even steps: a += b, d ^= a.  Odd steps: c += d, b ^= c.
      ix = ctl_i.step[0] ? ic : ia;
      iy = ctl_i.step[0] ? id : ib;
      iz = ctl_i.step[0] ? ib : id;
      sum = st_i[ix] + st_i[iy];
      st_o[ix] = sum;
      st_o[iz] = rotl(st_i[iz] ^ sum, r);
    end
  end

endmodule

>>> design/cck_checker.sv
// Port-level checks for the ChaCha keystream block, bound to the top level.
// Depends on cck_pkg and chacha_keystream_block.
module cck_checker import cck_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [63:0]       out_tdata,
  input logic [BEAT_W-1:0] out_tuser,
  input logic              out_tlast
);

  // A stalled output beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // The final beat is beat 3 (subkey) or beat 7 (keystream block).
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> (out_tuser == 3'd3) || (out_tuser == 3'd7))
    else $error("last beat at an unexpected position");

  // Once a counter is taken the block is busy with it.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a block is in progress");

  // Reset leaves no beat pending.
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind chacha_keystream_block cck_checker u_cck_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for chacha_keystream_block: counters go in, keystream beats come out.
// Depends on cck_pkg for the register index codes and the ChaCha constant words.
module tb;
  import cck_pkg::*;

  // Round select codes and mode values as the register map defines them.
  localparam logic [1:0] RSEL_8      = 2'd0;
  localparam logic [1:0] RSEL_12     = 2'd1;
  localparam logic [1:0] RSEL_20     = 2'd2;
  localparam logic [1:0] RSEL_SAT    = 2'd3;
  localparam logic       MODE_BLOCK  = 1'b0;
  localparam logic       MODE_SUBKEY = 1'b1;

  localparam int STALL_LIMIT   = 2000;
  localparam int LONG_HOLD     = 300;
  localparam int TAIL_CYCLES   = 100;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS   = 24;

  typedef struct packed {
    logic [63:0] data;
    logic [2:0]  index;
    logic        last;
  } beat_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [31:0]       in_tdata;    // [31:0] block_counter
  logic              out_tvalid;
  logic              out_tready;
  logic [63:0]       out_tdata;   // [63:0] out_data
  logic [BEAT_W-1:0] out_tuser;   // [2:0] beat_index
  logic              out_tlast;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  // Shadow copy of the configuration registers.
  logic [63:0] key_copy [4];
  logic [63:0] nonce_lo_copy;
  logic [63:0] nonce_hi_copy;
  logic [1:0]  rsel_copy;
  logic        mode_copy;

  // Working state of the predictor.
  word_t init_w [16];
  word_t mix_w  [16];

  beat_t keystream_q [$];
  beat_t head_beat;

  int errors;
  int items_sent;
  int beats_checked;
  int settings_loaded;
  int subkey_items;
  int idle_cycles;
  int hold_req;
  bit no_idle;

  chacha_keystream_block dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Left rotation built from a doubled word.
  function automatic word_t rotl32(input word_t x, input int n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

  task automatic quarter_round(input int a, input int b, input int c, input int d);
    mix_w[a] = mix_w[a] + mix_w[b];
    mix_w[d] = rotl32(mix_w[d] ^ mix_w[a], 16);
    mix_w[c] = mix_w[c] + mix_w[d];
    mix_w[b] = rotl32(mix_w[b] ^ mix_w[c], 12);
    mix_w[a] = mix_w[a] + mix_w[b];
    mix_w[d] = rotl32(mix_w[d] ^ mix_w[a], 8);
    mix_w[c] = mix_w[c] + mix_w[d];
    mix_w[b] = rotl32(mix_w[b] ^ mix_w[c], 7);
  endtask

  function automatic void add_beat(input word_t lo, input word_t hi, input int k,
                                   input logic last);
    beat_t nb;
    nb.data  = {hi, lo};
    nb.index = k[2:0];
    nb.last  = last;
    keystream_q.push_back(nb);
  endfunction

  // Computes the beats that one counter produces under the current settings.
  task automatic predict_keystream(input word_t counter);
    int dbl_rounds;
    int i;
    init_w[0] = SIGMA0;
    init_w[1] = SIGMA1;
    init_w[2] = SIGMA2;
    init_w[3] = SIGMA3;
    for (i = 0; i < 4; i++) begin
      init_w[4 + 2 * i] = key_copy[i][31:0];
      init_w[5 + 2 * i] = key_copy[i][63:32];
    end
    if (mode_copy == MODE_SUBKEY) begin
      init_w[12] = nonce_lo_copy[31:0];
      init_w[13] = nonce_lo_copy[63:32];
      init_w[14] = nonce_hi_copy[31:0];
      init_w[15] = nonce_hi_copy[63:32];
      dbl_rounds = ROUNDS_20 / 2;
    end else begin
      init_w[12] = counter;
      init_w[13] = nonce_lo_copy[31:0];
      init_w[14] = nonce_lo_copy[63:32];
      init_w[15] = nonce_hi_copy[31:0];
      case (rsel_copy)
        RSEL_8:  dbl_rounds = ROUNDS_8 / 2;
        RSEL_12: dbl_rounds = ROUNDS_12 / 2;
        default: dbl_rounds = ROUNDS_20 / 2;
      endcase
    end
    for (i = 0; i < 16; i++) mix_w[i] = init_w[i];
    repeat (dbl_rounds) begin
      quarter_round(0, 4, 8, 12);
      quarter_round(1, 5, 9, 13);
      quarter_round(2, 6, 10, 14);
      quarter_round(3, 7, 11, 15);
      quarter_round(0, 5, 10, 15);
      quarter_round(1, 6, 11, 12);
      quarter_round(2, 7, 8, 13);
      quarter_round(3, 4, 9, 14);
    end
    if (mode_copy == MODE_SUBKEY) begin
      // Subkey output: first and last rows of the state, no feed-forward.
      add_beat(mix_w[0], mix_w[1], 0, 1'b0);
      add_beat(mix_w[2], mix_w[3], 1, 1'b0);
      add_beat(mix_w[12], mix_w[13], 2, 1'b0);
      add_beat(mix_w[14], mix_w[15], 3, 1'b1);
      subkey_items++;
    end else begin
      for (i = 0; i < 16; i++) mix_w[i] = mix_w[i] + init_w[i];
      for (i = 0; i < 8; i++) add_beat(mix_w[2 * i], mix_w[2 * i + 1], i, i == 7);
    end
  endtask

  // Offers one counter after a random gap (none with no_idle) and waits for the handshake.
  task automatic send_counter(input word_t counter);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= counter;
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_keystream(counter);
    items_sent++;
  endtask

  // Stops offering and waits until every predicted beat has been seen.
  // The first edge keeps the next drive of the valid line in a later step.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (keystream_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_KEY_W0:     key_copy[0]   = value;
      CFG_KEY_W1:     key_copy[1]   = value;
      CFG_KEY_W2:     key_copy[2]   = value;
      CFG_KEY_W3:     key_copy[3]   = value;
      CFG_NONCE_LOW:  nonce_lo_copy = value;
      CFG_NONCE_HIGH: nonce_hi_copy = value;
      CFG_ROUND_SEL:  rsel_copy     = value[1:0];
      CFG_SUBKEY:     mode_copy     = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Waits for the block to go idle, then rewrites every register.
  // Unused upper bits of the narrow registers carry random junk.
  task automatic load_settings(input logic [63:0] k0, input logic [63:0] k1,
                               input logic [63:0] k2, input logic [63:0] k3,
                               input logic [63:0] nlo, input logic [63:0] nhi,
                               input logic [1:0] rsel, input logic mode);
    logic [63:0] junk;
    drain_results();
    write_reg(CFG_KEY_W0, k0);
    write_reg(CFG_KEY_W1, k1);
    write_reg(CFG_KEY_W2, k2);
    write_reg(CFG_KEY_W3, k3);
    write_reg(CFG_NONCE_LOW, nlo);
    write_reg(CFG_NONCE_HIGH, nhi);
    junk = {$urandom, $urandom};
    write_reg(CFG_ROUND_SEL, {junk[63:2], rsel});
    junk = {$urandom, $urandom};
    write_reg(CFG_SUBKEY, {junk[63:1], mode});
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  function automatic logic [63:0] random_reg64();
    case ($urandom_range(0, 7))
      0:       return 64'h0;
      1:       return {64{1'b1}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic word_t random_counter();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Reset values: zero key and nonce, 20 rounds, block mode.
  task automatic test_reset_defaults();
    send_counter(32'h0);
    send_counter(32'hffff_ffff);
  endtask

  // Every round select code, including the unused one that saturates to 20.
  task automatic test_round_counts();
    logic [1:0] codes [4];
    int i;
    codes[0] = RSEL_8;
    codes[1] = RSEL_12;
    codes[2] = RSEL_20;
    codes[3] = RSEL_SAT;
    for (i = 0; i < 4; i++) begin
      load_settings({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}},
                    {64{1'b1}}, {64{1'b1}}, codes[i], MODE_BLOCK);
      send_counter(32'h0);
      send_counter(32'hffff_ffff);
      send_counter(32'h8000_0001);
    end
  endtask

  // Distinct byte patterns show up any swap of key, nonce or word halves.
  task automatic test_key_layout();
    load_settings(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                  64'h1716151413121110, 64'h1f1e1d1c1b1a1918,
                  64'h4a00000009000000, 64'h0000000000000000, RSEL_20, MODE_BLOCK);
    send_counter(32'h1);
    load_settings(64'h0, 64'h0, 64'h0, 64'h0,
                  64'h8899aabbccddeeff, 64'h0123456789abcdef, RSEL_12, MODE_BLOCK);
    send_counter(32'h7fff_ffff);
  endtask

  // Subkey derivation ignores the counter and the round select.
  task automatic test_subkey_mode();
    load_settings(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                  64'h1716151413121110, 64'h1f1e1d1c1b1a1918,
                  64'h4a00000009000000, 64'h2741593100000000, RSEL_8, MODE_SUBKEY);
    send_counter(32'h0);
    send_counter(32'hffff_ffff);
    load_settings({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}},
                  {64{1'b1}}, {64{1'b1}}, RSEL_SAT, MODE_SUBKEY);
    send_counter($urandom);
  endtask

  // Random settings per phase, random counters within each phase.
  task automatic test_random_traffic();
    int p;
    int n;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      load_settings(random_reg64(), random_reg64(), random_reg64(), random_reg64(),
                    random_reg64(), random_reg64(), 2'($urandom_range(0, 3)),
                    ($urandom_range(0, 3) == 0) ? MODE_SUBKEY : MODE_BLOCK);
      for (n = 0; n < PHASE_ITEMS; n++) send_counter(random_counter());
    end
  endtask

  // A stretch with neither side idling.
  task automatic test_back_to_back();
    load_settings(random_reg64(), random_reg64(), random_reg64(), random_reg64(),
                  random_reg64(), random_reg64(), RSEL_8, MODE_BLOCK);
    no_idle = 1'b1;
    repeat (20) send_counter(random_counter());
    drain_results();
    no_idle = 1'b0;
  endtask

  // The receiver holds off for a long stretch while counters keep coming.
  task automatic test_output_backpressure();
    load_settings(random_reg64(), random_reg64(), random_reg64(), random_reg64(),
                  random_reg64(), random_reg64(), RSEL_20, MODE_BLOCK);
    hold_req = LONG_HOLD;
    repeat (6) send_counter(random_counter());
  endtask

  // The sender pauses until every beat is back, then resumes.
  task automatic test_pause_and_resume();
    load_settings(random_reg64(), random_reg64(), random_reg64(), random_reg64(),
                  random_reg64(), random_reg64(), RSEL_12, MODE_BLOCK);
    repeat (4) send_counter(random_counter());
    drain_results();
    repeat (4) send_counter(random_counter());
  endtask

  // Sequence of tests and the final verdict.
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_KEY_W0;
    cfg_wdata <= '0;
    key_copy[0]   = '0;
    key_copy[1]   = '0;
    key_copy[2]   = '0;
    key_copy[3]   = '0;
    nonce_lo_copy = '0;
    nonce_hi_copy = '0;
    rsel_copy     = RSEL_20;
    mode_copy     = MODE_BLOCK;
    errors = 0;
    items_sent = 0;
    beats_checked = 0;
    settings_loaded = 0;
    subkey_items = 0;
    hold_req = 0;
    no_idle = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_round_counts();
    test_key_layout();
    test_subkey_mode();
    test_random_traffic();
    test_back_to_back();
    test_output_backpressure();
    test_pause_and_resume();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d beats from %0d counters (%0d in subkey mode) under %0d settings,",
             beats_checked, items_sent, subkey_items, settings_loaded);
    $display("covering 8, 12, 20 and saturated rounds, random gaps and output stalls.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side: random stall before each beat (none with no_idle), or one long hold on request.
  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
      end else if (no_idle) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 5);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid === 1'b1 && out_tready));
    end
  end

  // Compare each accepted beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready) begin
      if (keystream_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, got data=%h index=%0d last=%0b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        head_beat = keystream_q.pop_front();
        beats_checked++;
        if (out_tdata !== head_beat.data) begin
          errors++;
          $display("%0t: data mismatch, expected %h, got %h",
                   $time, head_beat.data, out_tdata);
        end
        if (out_tuser !== head_beat.index) begin
          errors++;
          $display("%0t: beat index mismatch, expected %0d, got %0d",
                   $time, head_beat.index, out_tuser);
        end
        if (out_tlast !== head_beat.last) begin
          errors++;
          $display("%0t: last flag mismatch, expected %0b, got %0b",
                   $time, head_beat.last, out_tlast);
        end
      end
    end
  end

  // Watchdog: too many cycles without a beat on either channel ends the run.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_tvalid && in_tready === 1'b1) ||
        (out_tvalid === 1'b1 && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d beats still expected",
               $time, idle_cycles, keystream_q.size());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> files.f
design/cck_pkg.sv
design/cck_qr_step.sv
design/chacha_keystream_block.sv
design/cck_checker.sv
bench/tb.sv
